[src/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// Strict base64 decoder package
// Shared types, register indexes, error codes and the character classifier.
// ----------------------------------------------------------------------------
package sbd_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 25;
   localparam int LIMIT_WIDTH         = 25;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_INDEX_WIDTH     = 1;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 25'h100_0000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_URL_SAFE_MODE    = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_OUTPUT_BYTES = 1'd1;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_CHAR  = 3'd1,
      ERR_PAD   = 3'd2,
      ERR_LEN   = 3'd3,
      ERR_TAIL  = 3'd4,
      ERR_LIMIT = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_DIGIT   = 3'd1,
      KIND_PAD     = 3'd2,
      KIND_PAD_BAD = 3'd3,
      KIND_BAD     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       carries_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       done_res;
      logic       accepted;
      err_type    error_code;
   } rsp_type;

   // A character after classification, as held in the queue between front and back.
   typedef struct packed {
      kind_type   kind;
      logic [5:0] value;
      logic       is_last;
   } item_type;

   function automatic item_type classify(req_type req, logic url_safe);
      item_type   item;
      logic [7:0] ch;
      logic [7:0] diff;
      ch           = req.text_char;
      diff         = 8'd0;
      item.kind    = KIND_BAD;
      item.value   = 6'd0;
      item.is_last = req.is_last;
      if (!req.carries_char) begin
         item.kind = KIND_NONE;
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
         diff       = ch - CHAR_UP_A;
         item.kind  = KIND_DIGIT;
         item.value = diff[5:0];
      end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
         diff       = ch - CHAR_LO_A + 8'd26;
         item.kind  = KIND_DIGIT;
         item.value = diff[5:0];
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         diff       = ch - CHAR_ZERO + 8'd52;
         item.kind  = KIND_DIGIT;
         item.value = diff[5:0];
      end else if (ch == (url_safe ? CHAR_MINUS : CHAR_PLUS)) begin
         item.kind  = KIND_DIGIT;
         item.value = 6'd62;
      end else if (ch == (url_safe ? CHAR_UNDER : CHAR_SLASH)) begin
         item.kind  = KIND_DIGIT;
         item.value = 6'd63;
      end else if (ch == CHAR_PAD) begin
         item.kind = url_safe ? KIND_PAD_BAD : KIND_PAD;
      end
      return item;
   endfunction

endpackage

[src/sbd_fifo.sv]
// ----------------------------------------------------------------------------
// Small register queue
// A shallow first-in first-out queue; push and pop may happen in the same
// cycle, also when the queue is full.
// ----------------------------------------------------------------------------
module sbd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sbd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;
   assign do_push  = push && (!full || do_pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/sbd_front.sv]
// ----------------------------------------------------------------------------
// Decoder front end
// Takes characters, classifies them against the selected alphabet and
// queues the classified items for the back end.
// ----------------------------------------------------------------------------
module sbd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              url_safe,
   input  logic              req_push,
   input  sbd_pkg::req_type  req_data,
   output logic              req_full,
   input  logic              item_pop,
   output logic              item_empty,
   output sbd_pkg::item_type item_data
);

   localparam int ITEM_W = $bits(sbd_pkg::item_type);

   sbd_pkg::item_type class_item;
   logic [ITEM_W-1:0] queue_out;

   assign class_item = sbd_pkg::classify(req_data, url_safe);
   assign item_data  = sbd_pkg::item_type'(queue_out);

   // A request is taken only while req_full is low, as the interface promises.
   sbd_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (sbd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !req_full),
      .push_data (class_item),
      .full      (req_full),
      .pop       (item_pop),
      .empty     (item_empty),
      .pop_data  (queue_out)
   );

endmodule

[src/sbd_back.sv]
// ----------------------------------------------------------------------------
// Decoder back end
// Gathers digit bits, emits bytes, runs the canonical-form checks and queues
// one result per classified item.
// ----------------------------------------------------------------------------
module sbd_back #(
   parameter int COUNT_WIDTH = sbd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            url_safe,
   input  logic [sbd_pkg::LIMIT_WIDTH-1:0] max_bytes,
   input  logic                            item_empty,
   input  sbd_pkg::item_type               item_data,
   output logic                            item_pop,
   input  logic                            rsp_pop,
   output logic                            rsp_empty,
   output sbd_pkg::rsp_type                rsp_data
);

   localparam int RSP_W = $bits(sbd_pkg::rsp_type);
   localparam int CMP_W = (COUNT_WIDTH > sbd_pkg::LIMIT_WIDTH) ?
                          COUNT_WIDTH : sbd_pkg::LIMIT_WIDTH;

   logic [11:0]            buf_ff, buf_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [1:0]             phase_ff, phase_in;
   logic [1:0]             pad_ff, pad_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;
   sbd_pkg::err_type       err_ff, err_in;

   sbd_pkg::rsp_type  result;
   logic              out_full;
   logic [RSP_W-1:0]  out_bits;
   logic [3:0]        cnt_sum;
   logic [1:0]        len_sum;
   logic [5:0]        tail_bits;
   logic              at_limit;

   assign item_pop = !item_empty && (!out_full || rsp_pop);
   assign rsp_data = sbd_pkg::rsp_type'(out_bits);
   assign at_limit = ({{(CMP_W-COUNT_WIDTH){1'b0}}, bytes_ff} >=
                      {{(CMP_W-sbd_pkg::LIMIT_WIDTH){1'b0}}, max_bytes}) ||
                     (bytes_ff == {COUNT_WIDTH{1'b1}});

   always_comb begin
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      pad_in    = pad_ff;
      bytes_in  = bytes_ff;
      err_in    = err_ff;
      cnt_sum   = 4'd0;
      len_sum   = 2'd0;
      tail_bits = 6'd0;
      result    = '0;

      if (err_ff == sbd_pkg::ERR_NONE) begin
         case (item_data.kind)
            sbd_pkg::KIND_NONE: begin
            end
            sbd_pkg::KIND_PAD: begin
               if (pad_ff >= 2'd2) begin
                  err_in = sbd_pkg::ERR_PAD;
               end else begin
                  pad_in = pad_ff + 2'd1;
               end
            end
            sbd_pkg::KIND_PAD_BAD: begin
               err_in = sbd_pkg::ERR_PAD;
            end
            sbd_pkg::KIND_DIGIT: begin
               if (pad_ff != 2'd0) begin
                  err_in = sbd_pkg::ERR_PAD;
               end else begin
                  buf_in   = {buf_ff[5:0], item_data.value};
                  phase_in = phase_ff + 2'd1;
                  cnt_sum  = {1'b0, cnt_ff} + 4'd6;
                  cnt_in   = cnt_sum[2:0];
                  if (cnt_sum >= 4'd8) begin
                     cnt_in = 3'(cnt_sum - 4'd8);
                     if (at_limit) begin
                        err_in = sbd_pkg::ERR_LIMIT;
                     end else begin
                        bytes_in          = bytes_ff + 1'b1;
                        result.byte_valid = 1'b1;
                        case (cnt_in[2:1])
                           2'd1:    result.data_byte = buf_in[9:2];
                           2'd2:    result.data_byte = buf_in[11:4];
                           default: result.data_byte = buf_in[7:0];
                        endcase
                     end
                  end
               end
            end
            default: begin
               err_in = sbd_pkg::ERR_CHAR;
            end
         endcase
      end

      if (item_data.is_last && err_in == sbd_pkg::ERR_NONE) begin
         len_sum = phase_in + pad_in;
         if (url_safe ? (phase_in == 2'd1) : (len_sum != 2'd0)) begin
            err_in = sbd_pkg::ERR_LEN;
         end else begin
            case (cnt_in)
               3'd2:    tail_bits = {4'd0, buf_in[1:0]};
               3'd4:    tail_bits = {2'd0, buf_in[3:0]};
               3'd6:    tail_bits = buf_in[5:0];
               default: tail_bits = 6'd0;
            endcase
            if (tail_bits != 6'd0) begin
               err_in = sbd_pkg::ERR_TAIL;
            end
         end
      end

      result.error_code = err_in;
      result.done_res   = item_data.is_last;
      result.accepted   = item_data.is_last && (err_in == sbd_pkg::ERR_NONE);

      // The last item of a string leaves a clean slate for the next one.
      if (item_data.is_last) begin
         buf_in   = '0;
         cnt_in   = '0;
         phase_in = '0;
         pad_in   = '0;
         bytes_in = '0;
         err_in   = sbd_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         cnt_ff   <= '0;
         phase_ff <= '0;
         pad_ff   <= '0;
         bytes_ff <= '0;
         err_ff   <= sbd_pkg::ERR_NONE;
      end else if (item_pop) begin
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         pad_ff   <= pad_in;
         bytes_ff <= bytes_in;
         err_ff   <= err_in;
      end
   end

   sbd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (sbd_pkg::QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_pop),
      .push_data (result),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (out_bits)
   );

endmodule

[src/strict_base64_stream_decoder.sv]
// ----------------------------------------------------------------------------
// Strict base64 stream decoder
// Decodes one base64 character per transfer, checks canonical form and
// reports a verdict with the last character of each string.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction  Transfer when
//   request   req_push req_full req_data     in         req_push && !req_full
//   response  rsp_pop rsp_empty rsp_data     out        rsp_pop && !rsp_empty
//   control   csr_write csr_index csr_data   in         csr_write
//
// One character is taken per clock cycle while the response side keeps up. A
// character is registered in the classifier queue, then taken by the back
// end, and its response is registered in the result queue before it shows
// on the result ports. The rate is set by the state update in the back end,
// which handles one item per cycle while the result queue has room or is
// being read. Synchronous reset empties both queues, clears the string state
// and restores the default registers. A stalled response side fills the
// result queue, then the classifier queue, and only then raises req_full.
//
// The front end classifies each character against the selected alphabet; the
// back end owns the bit buffer, the digit and padding counts, the byte count
// and the sticky first error. Every request produces exactly one response.
// Register writes are expected only while no string is in flight.
// ----------------------------------------------------------------------------
module strict_base64_stream_decoder #(
   parameter int COUNT_WIDTH = sbd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  sbd_pkg::req_type                    req_data,
   output logic                                req_full,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output sbd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [sbd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sbd_pkg::LIMIT_WIDTH-1:0]     csr_data
);

   logic                            url_mode_ff, url_mode_in;
   logic [sbd_pkg::LIMIT_WIDTH-1:0] max_bytes_ff, max_bytes_in;

   logic              item_pop;
   logic              item_empty;
   sbd_pkg::item_type item_data;

   // Control registers: written directly, no read-back.
   always_comb begin
      url_mode_in  = url_mode_ff;
      max_bytes_in = max_bytes_ff;
      if (csr_write) begin
         case (csr_index)
            sbd_pkg::CSR_URL_SAFE_MODE:    url_mode_in  = csr_data[0];
            sbd_pkg::CSR_MAX_OUTPUT_BYTES: max_bytes_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         url_mode_ff  <= 1'b0;
         max_bytes_ff <= sbd_pkg::LIMIT_RESET;
      end else begin
         url_mode_ff  <= url_mode_in;
         max_bytes_ff <= max_bytes_in;
      end
   end

   // The front end sees the alphabet only; padding in URL-safe mode is marked
   // there so that the back end need not decode characters at all.
   sbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .url_safe   (url_mode_ff),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .item_pop   (item_pop),
      .item_empty (item_empty),
      .item_data  (item_data)
   );

   sbd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .url_safe   (url_mode_ff),
      .max_bytes  (max_bytes_ff),
      .item_empty (item_empty),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

   // A verdict of acceptance only comes with the end of a string.
   a_accept_needs_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.accepted |-> rsp_data.done_res)
      else $error("accepted without done_res");

   // An accepted string carries no error code.
   a_accept_no_error: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.accepted |-> rsp_data.error_code == sbd_pkg::ERR_NONE)
      else $error("accepted with an error code");

   // A response without a byte carries a zero data byte.
   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.byte_valid |-> rsp_data.data_byte == 8'd0)
      else $error("data byte set without byte_valid");

   // Reset leaves both queues empty.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule
